@@ hdl/hsv2rgb_pkg.sv @@
// hsv2rgb_pkg: shared types, sector codes and constants for the HSV to RGB converter.
// Used by hsv2rgb_ramp, hsv2rgb_mult and hsv_to_rgb_converter_core; no dependencies.
package hsv2rgb_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned HUE6_W  = 11;  // 6 * hue, up to 1530
  localparam int unsigned PROD_W  = 16;  // 8x8 products and the ramp numerator
  localparam int unsigned NUM_W   = 24;  // brightness * ramp numerator
  localparam int unsigned RECIP_W = 24;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // floor(x/255) for x < 2^24 as (x * ceil(2^31/255)) >> 31
  localparam logic [RECIP_W-1:0] RECIP_255   = 24'h808081;
  localparam int unsigned        RECIP_SHIFT = 31;

  // Hue sectors, named by the color at the start of each sixth of the circle
  typedef logic [2:0] sector_t;
  localparam sector_t SEC_RED     = 3'd0;
  localparam sector_t SEC_YELLOW  = 3'd1;
  localparam sector_t SEC_GREEN   = 3'd2;
  localparam sector_t SEC_CYAN    = 3'd3;
  localparam sector_t SEC_BLUE    = 3'd4;
  localparam sector_t SEC_MAGENTA = 3'd5;

  // Input word
  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_word_t;

  // Result word
  typedef struct packed {
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [3*CHAN_W-1:0] packed_color;
  } rgb_word_t;

  // After hue decode
  typedef struct packed {
    sector_t           sector;
    logic [CHAN_W-1:0] ramp;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } ramp_word_t;

  // After the multiply pipe: low channel done, mid channel still needs one /255
  typedef struct packed {
    sector_t           sector;
    logic [CHAN_W-1:0] brightness;
    logic [CHAN_W-1:0] low;
    logic [PROD_W-1:0] quo;
  } prod_word_t;

  // floor(x/255), exact for x <= 65279
  function automatic logic [CHAN_W-1:0] div255_16(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[PROD_W-1:CHAN_W]};
    return sum[PROD_W-1:CHAN_W];
  endfunction

endpackage

@@ hdl/hsv_to_rgb_converter_core.sv @@
// hsv_to_rgb_converter_core: top level of the 8-bit HSV to RGB converter.
// Depends on hsv2rgb_pkg, hsv2rgb_ramp and hsv2rgb_mult.
//
// Usage:
//   Input channel in_valid / in_stall / in_word carries one pixel word
//   (hue, saturation, brightness). Output channel out_valid / out_stall /
//   out_word carries red, green, blue and the packed color word
//   (red in 7:0, green in 15:8, blue in 23:16). A word moves on a rising
//   edge where valid is high and stall is low.
//   A word passes through five registered stages: hue decode, two
//   multiply stages, the reciprocal multiply that divides by 255, and the
//   output register with the final /255 and channel placement.
//   Throughput is one pixel per cycle while out_stall is low, with no
//   dependence between pixels.
//   Each stage has its own valid bit and holds its word while the stage
//   after it is full, so a stall on out_stall fills the five stages and
//   then raises in_stall; empty stages keep accepting meanwhile, and no
//   word is dropped or repeated.
//   Reset clears every valid bit; there is no other state.
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hsv_word_t in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output rgb_word_t out_word
);

  logic              ramp_ready;
  logic              ramp_valid;
  ramp_word_t        ramp_word;
  logic              mult_ready;
  logic              mult_valid;
  prod_word_t        mult_word;
  logic              out_ready;
  logic [CHAN_W-1:0] mid;
  logic [CHAN_W-1:0] top;
  logic [CHAN_W-1:0] low;
  rgb_word_t         word_nxt;
  rgb_word_t         word_r;
  logic              valid_r;

  hsv2rgb_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_ready  (ramp_ready),
    .out_valid (ramp_valid),
    .out_word  (ramp_word),
    .out_ready (mult_ready)
  );

  hsv2rgb_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ramp_valid),
    .in_word   (ramp_word),
    .in_ready  (mult_ready),
    .out_valid (mult_valid),
    .out_word  (mult_word),
    .out_ready (out_ready)
  );

  assign in_stall = !ramp_ready;

  // Final /255 and channel placement by sector
  assign mid = div255_16(mult_word.quo);
  assign top = mult_word.brightness;
  assign low = mult_word.low;

  always_comb begin
    case (mult_word.sector)
      SEC_RED: begin
        word_nxt.red = top; word_nxt.green = mid; word_nxt.blue = low;
      end
      SEC_YELLOW: begin
        word_nxt.red = mid; word_nxt.green = top; word_nxt.blue = low;
      end
      SEC_GREEN: begin
        word_nxt.red = low; word_nxt.green = top; word_nxt.blue = mid;
      end
      SEC_CYAN: begin
        word_nxt.red = low; word_nxt.green = mid; word_nxt.blue = top;
      end
      SEC_BLUE: begin
        word_nxt.red = mid; word_nxt.green = low; word_nxt.blue = top;
      end
      default: begin
        word_nxt.red = top; word_nxt.green = low; word_nxt.blue = mid;
      end
    endcase
    word_nxt.packed_color = {word_nxt.blue, word_nxt.green, word_nxt.red};
  end

  // Output register
  assign out_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_ready) begin
      valid_r <= mult_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mult_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

  // Mid channel must land between the low channel and brightness
  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    mult_valid |-> (mid >= low) && (mid <= top))
    else $error("mid channel outside low..brightness");

  // Multiply pipe holds its word while the output register is blocked
  a_mult_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mult_valid && !out_ready |=> mult_valid && $stable(mult_word))
    else $error("multiply pipe word changed while blocked");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Input is not stalled while the first stage is empty
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !ramp_valid |-> !in_stall)
    else $error("input stalled with empty first stage");

endmodule

@@ hdl/hsv2rgb_ramp.sv @@
// hsv2rgb_ramp: first pipeline stage, hue sector and ramp decode.
// Depends on hsv2rgb_pkg.
module hsv2rgb_ramp
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  hsv_word_t  in_word,
  output logic       in_ready,
  output logic       out_valid,
  output ramp_word_t out_word,
  input  logic       out_ready
);

  logic [HUE6_W-1:0] six_h;
  logic [HUE6_W-1:0] base;
  logic [HUE6_W-1:0] rem;
  sector_t           sector;
  ramp_word_t        word_nxt;
  ramp_word_t        word_r;
  logic              valid_r;

  // 6*hue as shift-and-add
  assign six_h = {1'b0, in_word.hue, 2'b00} + {2'b00, in_word.hue, 1'b0};

  // Sector by threshold compare; the top of the circle (6H = 1530) folds into magenta
  always_comb begin
    if (six_h >= 11'd1275) begin
      sector = SEC_MAGENTA;
      base   = 11'd1275;
    end else if (six_h >= 11'd1020) begin
      sector = SEC_BLUE;
      base   = 11'd1020;
    end else if (six_h >= 11'd765) begin
      sector = SEC_CYAN;
      base   = 11'd765;
    end else if (six_h >= 11'd510) begin
      sector = SEC_GREEN;
      base   = 11'd510;
    end else if (six_h >= 11'd255) begin
      sector = SEC_YELLOW;
      base   = 11'd255;
    end else begin
      sector = SEC_RED;
      base   = 11'd0;
    end
  end

  // Ramp rises in even sectors, falls in odd ones
  assign rem = six_h - base;

  always_comb begin
    word_nxt.sector     = sector;
    word_nxt.ramp       = sector[0] ? (CHAN_MAX - rem[CHAN_W-1:0]) : rem[CHAN_W-1:0];
    word_nxt.saturation = in_word.saturation;
    word_nxt.brightness = in_word.brightness;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

@@ hdl/hsv2rgb_mult.sv @@
// hsv2rgb_mult: three pipeline stages of multiplies for the low and mid channels.
// Depends on hsv2rgb_pkg.
module hsv2rgb_mult
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  ramp_word_t in_word,
  output logic       in_ready,
  output logic       out_valid,
  output prod_word_t out_word,
  input  logic       out_ready
);

  // Stage A: ramp numerator M = s*F + 255*(255-s), low numerator v*(255-s)
  logic [CHAN_W-1:0] inv_s;
  logic [PROD_W-1:0] sf_prod;
  logic [PROD_W-1:0] inv_s_255;
  logic [PROD_W-1:0] m_nxt;
  logic [PROD_W-1:0] low_num_nxt;
  logic              a_valid_r;
  logic              a_ready;
  sector_t           a_sector_r;
  logic [CHAN_W-1:0] a_bright_r;
  logic [PROD_W-1:0] a_m_r;
  logic [PROD_W-1:0] a_low_num_r;

  // Stage B: N = v*M, low channel
  logic [NUM_W-1:0]  n_nxt;
  logic              b_valid_r;
  logic              b_ready;
  sector_t           b_sector_r;
  logic [CHAN_W-1:0] b_bright_r;
  logic [CHAN_W-1:0] b_low_r;
  logic [NUM_W-1:0]  b_n_r;

  // Stage C: first /255 of N by reciprocal multiply
  logic [NUM_W+RECIP_W-1:0] recip_prod;
  logic                     c_valid_r;
  logic                     c_ready;
  prod_word_t               c_word_r;

  assign c_ready  = !c_valid_r || out_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // Stage A logic
  assign inv_s       = CHAN_MAX - in_word.saturation;
  assign sf_prod     = {8'd0, in_word.saturation} * {8'd0, in_word.ramp};
  assign inv_s_255   = {inv_s, 8'd0} - {8'd0, inv_s};
  assign m_nxt       = sf_prod + inv_s_255;
  assign low_num_nxt = {8'd0, in_word.brightness} * {8'd0, inv_s};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_sector_r  <= in_word.sector;
      a_bright_r  <= in_word.brightness;
      a_m_r       <= m_nxt;
      a_low_num_r <= low_num_nxt;
    end
  end

  // Stage B logic
  assign n_nxt = {8'd0, a_m_r} * {16'd0, a_bright_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_sector_r <= a_sector_r;
      b_bright_r <= a_bright_r;
      b_low_r    <= div255_16(a_low_num_r);
      b_n_r      <= n_nxt;
    end
  end

  // Stage C logic; quotient is at most 65025
  assign recip_prod = {{RECIP_W{1'b0}}, b_n_r} * {{NUM_W{1'b0}}, RECIP_255};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid_r) begin
      c_word_r.sector     <= b_sector_r;
      c_word_r.brightness <= b_bright_r;
      c_word_r.low        <= b_low_r;
      c_word_r.quo        <= recip_prod[RECIP_SHIFT +: PROD_W];
    end
  end

  assign out_valid = c_valid_r;
  assign out_word  = c_word_r;

endmodule
